/* rtl/core/greedy_load_migration_picker_macros.svh */
// Assertion macros for the picker RTL.
`ifndef GREEDY_LOAD_MIGRATION_PICKER_MACROS_SVH
`define GREEDY_LOAD_MIGRATION_PICKER_MACROS_SVH

// Checked on every rising edge outside reset.
`define GLMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define GLMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/glmp_pkg.sv */
package glmp_pkg;

  localparam int MAX_LOADS = 256;
  localparam int POS_W     = $clog2(MAX_LOADS + 1);

  localparam int DEPTH_W = 24;
  localparam int SIZE_W  = 16;
  localparam int IDX_W   = 8;
  localparam int KIND_W  = 2;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 64;

  localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DEPTH_W-1:0] dest_depth;
    logic [DEPTH_W-1:0] src_depth;
    logic [DEPTH_W-1:0] target_avg;
    logic [SIZE_W-1:0]  load_size;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  reply_kind;
    logic               flag;
    logic [IDX_W-1:0]   load_index;
    logic               status;
    logic               fallback_used;
    logic [DEPTH_W-1:0] new_src_depth;
    logic [DEPTH_W-1:0] new_dst_depth;
  } result_t;

endpackage

/* rtl/core/glmp_session.sv */
`include "greedy_load_migration_picker_macros.svh"

module glmp_session
  import glmp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output logic    has_result_o,
  output result_t result_o
);

  logic [DEPTH_W-1:0] dst_q, dst_d, src_q, src_d, avg_q, avg_d, total_q, total_d;
  logic [SIZE_W-1:0]  small_q, small_d;
  logic [IDX_W-1:0]   small_pos_q, small_pos_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               chosen_any_q, chosen_any_d;
  logic               eligible_q, eligible_d;
  logic               filled_q, filled_d;

  logic               elig_new;
  logic               pos_ok;
  logic               take;
  logic               smaller;
  logic [DEPTH_W:0]   load_sum;
  logic               fits;
  logic [DEPTH_W+1:0] lhs, rhs;
  logic [DEPTH_W-1:0] src_less;
  logic               fb;
  logic               done;
  logic [DEPTH_W:0]   fb_total, fin_total, moved;
  logic [DEPTH_W-1:0] new_src, new_dst;

  always_comb begin
    elig_new = (item_i.dest_depth < item_i.target_avg) &&
               (item_i.src_depth > item_i.target_avg) &&
               ({1'b0, item_i.src_depth} >= {item_i.dest_depth, 1'b0});

    pos_ok   = pos_q < POS_W'(MAX_LOADS);
    take     = eligible_q && !filled_q && pos_ok && (item_i.load_size != '0);
    smaller  = (small_q == '0) || (item_i.load_size < small_q);
    load_sum = {1'b0, total_q} + (DEPTH_W+1)'(item_i.load_size);
    fits     = load_sum <= {1'b0, avg_q};

    // Fallback test 2*(dst+min) < 3*(src-min); a negative right side never wins.
    lhs      = {({1'b0, dst_q} + (DEPTH_W+1)'(small_q)), 1'b0};
    src_less = src_q - DEPTH_W'(small_q);
    rhs      = {2'b00, src_less} + {1'b0, src_less, 1'b0};
    fb       = eligible_q && !chosen_any_q && (small_q != '0) &&
               (src_q >= DEPTH_W'(small_q)) && (lhs < rhs);
    done     = eligible_q && (chosen_any_q || fb);
    fb_total = {1'b0, total_q} + (fb ? (DEPTH_W+1)'(small_q) : '0);
    fin_total = done ? fb_total : {1'b0, dst_q};
    moved    = fin_total - {1'b0, dst_q};
    new_src  = (moved >= {1'b0, src_q}) ? '0 : (src_q - moved[DEPTH_W-1:0]);
    new_dst  = fin_total[DEPTH_W] ? '1 : fin_total[DEPTH_W-1:0];
  end

  always_comb begin
    dst_d        = dst_q;
    src_d        = src_q;
    avg_d        = avg_q;
    total_d      = total_q;
    small_d      = small_q;
    small_pos_d  = small_pos_q;
    pos_d        = pos_q;
    chosen_any_d = chosen_any_q;
    eligible_d   = eligible_q;
    filled_d     = filled_q;

    result_o            = '0;
    result_o.reply_kind = item_i.kind;
    has_result_o        = 1'b1;

    case (item_i.kind)
      KIND_BEGIN: begin
        dst_d        = item_i.dest_depth;
        src_d        = item_i.src_depth;
        avg_d        = item_i.target_avg;
        total_d      = item_i.dest_depth;
        small_d      = '0;
        small_pos_d  = '0;
        pos_d        = '0;
        chosen_any_d = 1'b0;
        filled_d     = 1'b0;
        eligible_d   = elig_new;
        result_o.flag = elig_new;
      end
      KIND_LOAD: begin
        if (pos_ok) begin
          pos_d = pos_q + 1'b1;
        end
        result_o.load_index = pos_q[IDX_W-1:0];
        if (take) begin
          if (smaller) begin
            small_d     = item_i.load_size;
            small_pos_d = pos_q[IDX_W-1:0];
          end
          if (fits) begin
            total_d       = load_sum[DEPTH_W-1:0];
            chosen_any_d  = 1'b1;
            result_o.flag = 1'b1;
          end
          filled_d = (fits ? load_sum[DEPTH_W-1:0] : total_q) == avg_q;
        end
      end
      KIND_FINISH: begin
        result_o.load_index    = fb ? small_pos_q : '0;
        result_o.status        = !done;
        result_o.fallback_used = fb;
        result_o.new_src_depth = new_src;
        result_o.new_dst_depth = new_dst;
        dst_d      = new_dst;
        src_d      = new_src;
        total_d    = new_dst;
        eligible_d = 1'b0;
        filled_d   = 1'b0;
      end
      default: begin
        has_result_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_q        <= '0;
      src_q        <= '0;
      avg_q        <= '0;
      total_q      <= '0;
      small_q      <= '0;
      small_pos_q  <= '0;
      pos_q        <= '0;
      chosen_any_q <= 1'b0;
      eligible_q   <= 1'b0;
      filled_q     <= 1'b0;
    end else if (fire_i) begin
      dst_q        <= dst_d;
      src_q        <= src_d;
      avg_q        <= avg_d;
      total_q      <= total_d;
      small_q      <= small_d;
      small_pos_q  <= small_pos_d;
      pos_q        <= pos_d;
      chosen_any_q <= chosen_any_d;
      eligible_q   <= eligible_d;
      filled_q     <= filled_d;
    end
  end

  `GLMP_ASSERT(a_total_within_avg, eligible_q |-> (total_q <= avg_q), "running total above average")
  `GLMP_ASSERT(a_filled_consistent, filled_q |-> (eligible_q && (total_q == avg_q)), "filled without a full total")
  `GLMP_ASSERT(a_pos_bounded, pos_q <= POS_W'(MAX_LOADS), "load position past its limit")

endmodule

/* rtl/core/greedy_load_migration_picker.sv */
// Greedy load migration picker.
// Input stream: s_axis_tuser carries the item kind (begin, load, finish) and
// s_axis_tdata the depths and load size. Every begin, load or finish item
// yields exactly one result on the master stream; kind three is dropped.
// Result tuser echoes the kind; tdata holds the verdict flag, load index,
// summary status, fallback marker and the new source and destination depths.
// The input register holds each transfer; the session logic then turns it into
// a result in the result register. One item is taken every cycle while the
// receiver keeps up, since each verdict needs only one add and compare against
// the session registers.
// Reset clears the session: the block then behaves as if no begin had come,
// so loads are not chosen and a finish reports nothing migrated.
// When the receiver holds off, the result register keeps its transfer, the
// input register takes one more item, and s_axis_tready then drops until the
// result is taken.
module greedy_load_migration_picker
  import glmp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // dest_depth [23:0], src_depth [47:24], target_avg [71:48], load_size [87:72]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind [1:0]
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // flag [0], load_index [8:1], status [9], fallback_used [10],
  // new_src_depth [34:11], new_dst_depth [58:35], zero [63:59]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // reply_kind [1:0]
  output logic [KIND_W-1:0]     m_axis_tuser
);

  item_t   in_q;
  logic    in_vld_q;
  result_t out_q;
  logic    out_vld_q;
  logic    fire;
  logic    has_result;
  result_t result;

  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.kind       <= s_axis_tuser;
      in_q.dest_depth <= s_axis_tdata[23:0];
      in_q.src_depth  <= s_axis_tdata[47:24];
      in_q.target_avg <= s_axis_tdata[71:48];
      in_q.load_size  <= s_axis_tdata[87:72];
    end
  end

  glmp_session u_session (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (in_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && has_result) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_result) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.reply_kind;
  assign m_axis_tdata  = {5'b0, out_q.new_dst_depth, out_q.new_src_depth,
                          out_q.fallback_used, out_q.status, out_q.load_index,
                          out_q.flag};

endmodule

/* sim/tb_greedy_load_migration_picker.sv */
`timescale 1ns / 1ps

module tb_greedy_load_migration_picker;
  import glmp_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int PLAN_LEN = 25;
  localparam int RANDOM_ITEMS = 1250;

  // Replies that can be read straight off the rules.
  localparam result_t UNTYPED       = '0;
  localparam result_t LOAD_IDLE0    = {KIND_LOAD, 1'b0, 8'd0, 1'b0, 1'b0, 24'd0, 24'd0};
  localparam result_t FINISH_EMPTY  = {KIND_FINISH, 1'b0, 8'd0, 1'b1, 1'b0, 24'd0, 24'd0};
  localparam result_t BEGIN_REFUSED = {KIND_BEGIN, 1'b0, 8'd0, 1'b0, 1'b0, 24'd0, 24'd0};
  localparam result_t BEGIN_OPEN    = {KIND_BEGIN, 1'b1, 8'd0, 1'b0, 1'b0, 24'd0, 24'd0};

  typedef struct packed {
    item_t   it;
    logic    fixed;
    result_t reply;
  } plan_row_t;

  typedef struct {
    bit      fixed;
    result_t reply;
  } typed_reply_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [KIND_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;

  greedy_load_migration_picker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Session state as the block should hold it.
  logic [DEPTH_W-1:0] sess_dst = '0;
  logic [DEPTH_W-1:0] sess_src = '0;
  logic [DEPTH_W-1:0] sess_avg = '0;
  logic [DEPTH_W-1:0] sess_total = '0;
  logic [SIZE_W-1:0]  min_size = '0;
  logic [IDX_W-1:0]   min_pos = '0;
  logic [POS_W-1:0]   picked_cnt = '0;
  logic [POS_W-1:0]   load_pos = '0;
  logic               sess_open = 1'b0;
  logic               sess_full = 1'b0;

  result_t      pending_replies [$];
  typed_reply_t typed_replies [$];
  plan_row_t    plan [PLAN_LEN];

  int sender_gap_pct = 0;
  int sink_stall_pct = 0;
  int items_sent = 0;
  int failures = 0;
  int n_begin = 0, n_open = 0, n_load = 0, n_finish = 0;
  int n_chosen = 0, n_fallback = 0, n_checked = 0;

  // Works out the reply to one item and advances the session; no reply for the spare kind.
  function automatic bit judge_item(input item_t it, output result_t r);
    logic [POS_W-1:0]   pos;
    logic [DEPTH_W-1:0] nsrc;
    longint             total, moved, lhs, rhs;
    bit                 chosen, fb, done;
    r = '0;
    case (it.kind)
      KIND_BEGIN: begin
        sess_dst   = it.dest_depth;
        sess_src   = it.src_depth;
        sess_avg   = it.target_avg;
        sess_total = it.dest_depth;
        min_size   = '0;
        min_pos    = '0;
        picked_cnt = '0;
        load_pos   = '0;
        sess_full  = 1'b0;
        sess_open  = (sess_dst < sess_avg) && (sess_src > sess_avg) &&
                     (longint'(sess_src) >= 2 * longint'(sess_dst));
        r.reply_kind = KIND_BEGIN;
        r.flag       = sess_open;
        return 1'b1;
      end
      KIND_LOAD: begin
        pos    = load_pos;
        chosen = 1'b0;
        if (load_pos < MAX_LOADS) load_pos = load_pos + 1'b1;
        if (sess_open && !sess_full && pos < MAX_LOADS && it.load_size != 0) begin
          if (min_size == 0 || it.load_size < min_size) begin
            min_size = it.load_size;
            min_pos  = pos[IDX_W-1:0];
          end
          if (longint'(sess_total) + longint'(it.load_size) <= longint'(sess_avg)) begin
            sess_total = sess_total + it.load_size;
            picked_cnt = picked_cnt + 1'b1;
            chosen     = 1'b1;
          end
          if (sess_total == sess_avg) sess_full = 1'b1;
        end
        r.reply_kind = KIND_LOAD;
        r.flag       = chosen;
        r.load_index = pos[IDX_W-1:0];
        return 1'b1;
      end
      KIND_FINISH: begin
        total = longint'(sess_total);
        fb    = 1'b0;
        if (sess_open && picked_cnt == 0 && min_size != 0) begin
          // The fallback test is signed: the source side can go negative.
          lhs = 2 * (longint'(sess_dst) + longint'(min_size));
          rhs = 3 * (longint'(sess_src) - longint'(min_size));
          if (lhs < rhs) begin
            total = total + longint'(min_size);
            fb    = 1'b1;
          end
        end
        done = sess_open && (picked_cnt != 0 || fb);
        if (!done) total = longint'(sess_dst);
        moved = total - longint'(sess_dst);
        nsrc  = (moved >= longint'(sess_src)) ? '0 : DEPTH_W'(longint'(sess_src) - moved);
        if (total > longint'(24'hFFFFFF)) total = longint'(24'hFFFFFF);
        r.reply_kind    = KIND_FINISH;
        r.load_index    = fb ? min_pos : '0;
        r.status        = !done;
        r.fallback_used = fb;
        r.new_src_depth = nsrc;
        r.new_dst_depth = DEPTH_W'(total);
        sess_dst   = DEPTH_W'(total);
        sess_src   = nsrc;
        sess_total = DEPTH_W'(total);
        sess_open  = 1'b0;
        sess_full  = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic item_t random_item(input logic [KIND_W-1:0] k);
    item_t r;
    r.kind       = k;
    r.dest_depth = DEPTH_W'($urandom);
    r.src_depth  = DEPTH_W'($urandom);
    r.target_avg = DEPTH_W'($urandom);
    r.load_size  = SIZE_W'($urandom);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // Offers one item and returns at the edge where its transfer completes.
  task automatic push_item(input item_t it, input bit fixed, input result_t reply);
    typed_reply_t pin;
    while ($urandom_range(99) < sender_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    pin.fixed = fixed;
    pin.reply = reply;
    typed_replies.push_back(pin);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {it.load_size, it.target_avg, it.src_depth, it.dest_depth};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // One rebalance: a begin, a run of loads and usually a finish, with some noise.
  task automatic run_session(input bit long_run);
    item_t it;
    int    avg, dst, src, hi, cap, flavour, roll, n_loads;
    if ($urandom_range(9) == 0)
      push_item(random_item($urandom_range(1) ? KIND_SPARE : KIND_LOAD), 1'b0, UNTYPED);
    it   = random_item(KIND_BEGIN);
    roll = $urandom_range(9);
    avg  = int'(it.target_avg);
    dst  = int'(it.dest_depth);
    src  = int'(it.src_depth);
    if (long_run) begin
      // Wide gap and random load sizes, so loads past the list limit could still fit.
      dst = 0;
      src = 24'hFFFFFF;
      avg = 24'hFFFFFE;
    end else if (roll < 5) begin
      avg = $urandom_range(5000, 1);
      dst = $urandom_range(avg - 1, 0);
      src = $urandom_range(3 * avg + 10, (2 * dst > avg) ? 2 * dst : avg + 1);
    end else if (roll < 8) begin
      avg = $urandom_range(24'hFFFFFE, 1);
      hi  = (avg - 1 < 24'h7FFFFF) ? avg - 1 : 24'h7FFFFF;
      dst = $urandom_range(hi, (hi > 300000) ? hi - 300000 : 0);
      src = $urandom_range(24'hFFFFFF, (2 * dst > avg) ? 2 * dst : avg + 1);
    end
    it.dest_depth = DEPTH_W'(dst);
    it.src_depth  = DEPTH_W'(src);
    it.target_avg = DEPTH_W'(avg);
    push_item(it, 1'b0, UNTYPED);

    cap     = avg - dst;
    cap     = (cap < 1) ? 1 : ((cap > 65535) ? 65535 : cap);
    flavour = $urandom_range(3);
    n_loads = long_run ? $urandom_range(264, 257) : $urandom_range(12, 0);
    for (int i = 0; i < n_loads; i++) begin
      it   = random_item(KIND_LOAD);
      roll = $urandom_range(19);
      if (long_run) begin
      end else if (roll == 0) begin
        it.load_size = '0;
      end else if (roll == 1) begin
      end else if (flavour == 0 && cap < 65535) begin
        // Loads too big for the gap: unless a random one fits, nothing is chosen and the fallback decides.
        it.load_size = SIZE_W'($urandom_range(65535, cap + 1));
      end else if (roll < 12) begin
        it.load_size = SIZE_W'($urandom_range(cap, 1));
      end else begin
        it.load_size = SIZE_W'($urandom_range(cap / 4 + 1, 1));
      end
      push_item(it, 1'b0, UNTYPED);
      if ($urandom_range(39) == 0) push_item(random_item(KIND_SPARE), 1'b0, UNTYPED);
    end

    roll = $urandom_range(19);
    if (roll != 0) push_item(random_item(KIND_FINISH), 1'b0, UNTYPED);
    if (roll > 16) push_item(random_item(KIND_FINISH), 1'b0, UNTYPED);
  endtask

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk_i) begin
    item_t        seen;
    result_t      want;
    typed_reply_t pin;
    bit           has_reply;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen.kind       = s_axis_tuser;
        seen.dest_depth = s_axis_tdata[23:0];
        seen.src_depth  = s_axis_tdata[47:24];
        seen.target_avg = s_axis_tdata[71:48];
        seen.load_size  = s_axis_tdata[87:72];
        pin = typed_replies.pop_front();
        has_reply = judge_item(seen, want);
        if (has_reply) begin
          pending_replies.push_back(pin.fixed ? pin.reply : want);
          case (want.reply_kind)
            KIND_BEGIN: begin
              n_begin++;
              n_open += want.flag;
            end
            KIND_LOAD: begin
              n_load++;
              n_chosen += want.flag;
            end
            default: begin
              n_finish++;
              n_fallback += want.fallback_used;
            end
          endcase
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_replies.size() == 0) begin
          $error("unexpected result: tuser %0h tdata %0h", m_axis_tuser, m_axis_tdata);
          failures++;
        end else begin
          want = pending_replies.pop_front();
          n_checked++;
          check_field("reply_kind", want.reply_kind, m_axis_tuser);
          check_field("flag", want.flag, m_axis_tdata[0]);
          check_field("load_index", want.load_index, m_axis_tdata[8:1]);
          check_field("status", want.status, m_axis_tdata[9]);
          check_field("fallback_used", want.fallback_used, m_axis_tdata[10]);
          check_field("new_src_depth", want.new_src_depth, m_axis_tdata[34:11]);
          check_field("new_dst_depth", want.new_dst_depth, m_axis_tdata[58:35]);
          check_field("tdata pad", '0, m_axis_tdata[63:59]);
        end
      end
    end
  end

  initial begin
    // kind, dest_depth, src_depth, target_avg, load_size, typed, reply
    plan[0]  = {KIND_LOAD,   24'd0, 24'd0, 24'd0, 16'd5, 1'b1, LOAD_IDLE0};
    plan[1]  = {KIND_FINISH, 24'd0, 24'd0, 24'd0, 16'd0, 1'b1, FINISH_EMPTY};
    plan[2]  = {KIND_SPARE,  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0, UNTYPED};
    plan[3]  = {KIND_BEGIN,  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1, BEGIN_REFUSED};
    plan[4]  = {KIND_LOAD,   24'd0, 24'd0, 24'd0, 16'hFFFF, 1'b1, LOAD_IDLE0};
    plan[5]  = {KIND_FINISH, 24'd0, 24'd0, 24'd0, 16'd0, 1'b0, UNTYPED};
    plan[6]  = {KIND_FINISH, 24'd0, 24'd0, 24'd0, 16'd0, 1'b0, UNTYPED};
    plan[7]  = {KIND_BEGIN,  24'd10, 24'd100, 24'd40, 16'd0, 1'b1, BEGIN_OPEN};
    plan[8]  = {KIND_LOAD,   24'd0, 24'd0, 24'd0, 16'd0, 1'b0, UNTYPED};
    plan[9]  = {KIND_LOAD,   24'd0, 24'd0, 24'd0, 16'd20, 1'b0, UNTYPED};
    plan[10] = {KIND_LOAD,   24'd0, 24'd0, 24'd0, 16'd15, 1'b0, UNTYPED};
    plan[11] = {KIND_LOAD,   24'd0, 24'd0, 24'd0, 16'd10, 1'b0, UNTYPED};
    plan[12] = {KIND_LOAD,   24'd0, 24'd0, 24'd0, 16'd1, 1'b0, UNTYPED};
    plan[13] = {KIND_FINISH, 24'd0, 24'd0, 24'd0, 16'd0, 1'b0, UNTYPED};
    plan[14] = {KIND_BEGIN,  24'd100, 24'd1000, 24'd150, 16'd0, 1'b1, BEGIN_OPEN};
    plan[15] = {KIND_LOAD,   24'd0, 24'd0, 24'd0, 16'hFFFF, 1'b0, UNTYPED};
    plan[16] = {KIND_LOAD,   24'd0, 24'd0, 24'd0, 16'd200, 1'b0, UNTYPED};
    plan[17] = {KIND_FINISH, 24'd0, 24'd0, 24'd0, 16'd0, 1'b0, UNTYPED};
    plan[18] = {KIND_BEGIN,  24'd0, 24'hFFFFFF, 24'h7FFFFF, 16'd0, 1'b1, BEGIN_OPEN};
    plan[19] = {KIND_LOAD,   24'd0, 24'd0, 24'd0, 16'hFFFF, 1'b0, UNTYPED};
    plan[20] = {KIND_FINISH, 24'd0, 24'd0, 24'd0, 16'd0, 1'b0, UNTYPED};
    plan[21] = {KIND_BEGIN,  24'd1000, 24'd1400, 24'd1200, 16'd0, 1'b1, BEGIN_REFUSED};
    plan[22] = {KIND_BEGIN,  24'd0, 24'd2, 24'd1, 16'd0, 1'b1, BEGIN_OPEN};
    plan[23] = {KIND_LOAD,   24'd0, 24'd0, 24'd0, 16'd5, 1'b0, UNTYPED};
    plan[24] = {KIND_FINISH, 24'd0, 24'd0, 24'd0, 16'd0, 1'b0, UNTYPED};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int row = 0; row < PLAN_LEN; row++)
      push_item(plan[row].it, plan[row].fixed, plan[row].reply);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_gap_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          sender_gap_pct = 60;
          sink_stall_pct = 0;
        end
        2: begin
          sender_gap_pct = 0;
          sink_stall_pct = 60;
        end
        default: begin
          sender_gap_pct = 11;
          sink_stall_pct = 11;
        end
      endcase
      run_session(ph == 1 || ph == 3);
      while (items_sent < PLAN_LEN + (ph + 1) * RANDOM_ITEMS / 4) run_session(1'b0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d items: %0d begins (%0d eligible), %0d loads, %0d finishes.",
             items_sent, n_begin, n_open, n_load, n_finish);
    $display("Checked %0d results, with %0d loads chosen and %0d fallback picks.",
             n_checked, n_chosen, n_fallback);
    if (failures == 0 && pending_replies.size() == 0) begin
      $display("tb_greedy_load_migration_picker passed");
    end else begin
      $display("tb_greedy_load_migration_picker failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Timed out with %0d results still pending.", pending_replies.size());
    $display("tb_greedy_load_migration_picker failed");
    $finish;
  end

endmodule
